// File: src/lsc_pkg.sv
package lsc_pkg;

	localparam int CACHE_ENTRIES_DEF = 64;
	localparam int SECTOR_W = 32;
	localparam int SLOT_W = 6;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_FLUSH = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [SECTOR_W-1:0] sector;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic                fetch_needed;
		logic                writeback_valid;
		logic [SECTOR_W-1:0] writeback_sector;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic tag_eq;
		logic rank_eq;
		logic rank_lt;
	} lsc_cmp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_LOOKUP_END,
		ST_DECIDE,
		ST_PROMOTE,
		ST_PROMOTE_END,
		ST_EMIT,
		ST_FL_MAP,
		ST_FL_MAP_END,
		ST_FL_READ,
		ST_FL_TAG,
		ST_FL_EMIT
	} state_t;

endpackage

// File: src/lsc_ram.sv
module lsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/lsc_unit.sv
module lsc_unit import lsc_pkg::*; #(
	parameter int RANK_W = 6
) (
	input  logic [SECTOR_W-1:0] tag,
	input  logic [SECTOR_W-1:0] key,
	input  logic [RANK_W-1:0]   rank,
	input  logic [RANK_W-1:0]   target,
	input  logic [RANK_W:0]     limit,
	output lsc_cmp_t            cmp,
	output logic [RANK_W-1:0]   rank_inc
);

	// Shared by the lookup and promotion passes: tag match and oldest-entry detection during lookup,
	// the ageing test and increment during promotion.
	always_comb begin
		cmp.tag_eq  = (tag == key);
		cmp.rank_eq = (rank == target);
		cmp.rank_lt = ({1'b0, rank} < limit);
		rank_inc    = rank + RANK_W'(1);
	end

endmodule

// File: src/lru_sector_cache_controller.sv
// A read or write request makes one pass over the tag and rank memories for lookup,
// then one over the rank memory to promote, before its result is given.
// A flush maps ranks to slots in one pass, then writes back each resident entry in turn.
// One request is worked on at a time; a new one is taken only in idle, which may be while
// the last result still waits at the output.
// Reset clears the valid bits and occupancy count at once; no clearing pass is needed.
module lru_sector_cache_controller import lsc_pkg::*; #(
	parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	localparam int IDX_W = $clog2(CACHE_ENTRIES);
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);
	localparam logic [IDX_W:0]   AGE_ALL  = (IDX_W + 1)'(CACHE_ENTRIES);

	state_t state_q, state_d;

	logic [1:0]               action_q;
	logic [SECTOR_W-1:0]      sector_q;
	logic [IDX_W-1:0]         addr_q;
	logic                     rd_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     hit_q;
	logic [IDX_W-1:0]         hslot_q;
	logic [IDX_W-1:0]         hrank_q;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_q;
	logic [IDX_W-1:0]         old_slot_q;
	logic [SECTOR_W-1:0]      old_tag_q;
	logic [IDX_W-1:0]         sel_q;
	logic [IDX_W:0]           limit_q;
	rsp_t                     res_q;
	logic [CNT_W-1:0]         count_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]         flush_r_q;
	logic [IDX_W-1:0]         wb_slot_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic                tag_we, tag_re, rank_we, rank_re, inv_we, inv_re;
	logic [IDX_W-1:0]    tag_waddr, tag_raddr, rank_wdata;
	logic [SECTOR_W-1:0] tag_rdata;
	logic [IDX_W-1:0]    rank_rdata, inv_rdata, rank_inc, oldest_rank, victim;
	lsc_cmp_t            cmp;
	logic                rsp_free, load_rsp, scanning, full;
	rsp_t                rsp_next;

	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign oldest_rank = IDX_W'(count_q - CNT_W'(1));
	assign full        = (count_q == FULL_CNT);
	assign victim      = full ? old_slot_q : free_q;
	assign scanning    = (state_q == ST_LOOKUP) || (state_q == ST_PROMOTE)
		|| (state_q == ST_FL_MAP);

	lsc_ram #(.WIDTH(SECTOR_W), .DEPTH(CACHE_ENTRIES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (sector_q),
		.re    (tag_re),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	lsc_ram #(.WIDTH(IDX_W), .DEPTH(CACHE_ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_wdata),
		.re    (rank_re),
		.raddr (addr_q),
		.rdata (rank_rdata)
	);

	// Rank to slot map, built at the start of a flush so entries leave oldest first.
	lsc_ram #(.WIDTH(IDX_W), .DEPTH(CACHE_ENTRIES)) u_inv_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (rank_rdata),
		.wdata (idx_s1),
		.re    (inv_re),
		.raddr (flush_r_q),
		.rdata (inv_rdata)
	);

	lsc_unit #(.RANK_W(IDX_W)) u_unit (
		.tag      (tag_rdata),
		.key      (sector_q),
		.rank     (rank_rdata),
		.target   (oldest_rank),
		.limit    (limit_q),
		.cmp      (cmp),
		.rank_inc (rank_inc)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_data.action) inside
						ACT_READ, ACT_WRITE: state_d = ST_LOOKUP;
						ACT_FLUSH: state_d = (count_q == '0) ? ST_IDLE : ST_FL_MAP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				if (addr_q == LAST_IDX) begin
					state_d = ST_LOOKUP_END;
				end
			end
			ST_LOOKUP_END: state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_PROMOTE;
			ST_PROMOTE: begin
				if (addr_q == LAST_IDX) begin
					state_d = ST_PROMOTE_END;
				end
			end
			ST_PROMOTE_END: state_d = ST_EMIT;
			ST_EMIT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FL_MAP: begin
				if (addr_q == LAST_IDX) begin
					state_d = ST_FL_MAP_END;
				end
			end
			ST_FL_MAP_END: state_d = ST_FL_READ;
			ST_FL_READ: state_d = ST_FL_TAG;
			ST_FL_TAG: state_d = ST_FL_EMIT;
			ST_FL_EMIT: begin
				if (rsp_free) begin
					state_d = (flush_r_q == '0) ? ST_IDLE : ST_FL_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		tag_we     = 1'b0;
		tag_waddr  = victim;
		tag_re     = 1'b0;
		tag_raddr  = addr_q;
		rank_re    = 1'b0;
		rank_we    = 1'b0;
		rank_wdata = (idx_s1 == sel_q) ? '0 : rank_inc;
		inv_re     = 1'b0;
		inv_we     = 1'b0;
		load_rsp   = 1'b0;
		rsp_next   = res_q;
		unique case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_LOOKUP: begin
				tag_re  = 1'b1;
				rank_re = 1'b1;
			end
			ST_DECIDE: tag_we = !hit_q;
			ST_PROMOTE, ST_PROMOTE_END: begin
				rank_re = (state_q == ST_PROMOTE);
				// The promoted slot goes to rank 0; younger valid entries age by one.
				rank_we = rd_s1
					&& ((idx_s1 == sel_q) || (valid_q[idx_s1] && cmp.rank_lt));
			end
			ST_EMIT: load_rsp = rsp_free;
			ST_FL_MAP, ST_FL_MAP_END: begin
				rank_re = (state_q == ST_FL_MAP);
				inv_we  = rd_s1 && valid_q[idx_s1];
			end
			ST_FL_READ: inv_re = 1'b1;
			ST_FL_TAG: begin
				tag_re    = 1'b1;
				tag_raddr = inv_rdata;
			end
			ST_FL_EMIT: begin
				load_rsp                  = rsp_free;
				rsp_next.hit              = 1'b0;
				rsp_next.slot             = SLOT_W'(wb_slot_q);
				rsp_next.fetch_needed     = 1'b0;
				rsp_next.writeback_valid  = 1'b1;
				rsp_next.writeback_sector = tag_rdata;
				rsp_next.last             = (flush_r_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			rd_s1        <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			count_q      <= '0;
			valid_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= scanning;
			if (scanning) begin
				addr_q <= (addr_q == LAST_IDX) ? '0 : addr_q + IDX_W'(1);
			end
			if (state_q == ST_IDLE && req_valid) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (rd_s1 && (state_q == ST_LOOKUP || state_q == ST_LOOKUP_END)) begin
				if (valid_q[idx_s1] && cmp.tag_eq && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!valid_q[idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == ST_DECIDE && !hit_q && !full) begin
				valid_q[victim] <= 1'b1;
				count_q         <= count_q + CNT_W'(1);
			end
			if (state_q == ST_FL_EMIT && rsp_free && flush_r_q == '0) begin
				valid_q <= '0;
				count_q <= '0;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (state_q == ST_IDLE && req_valid) begin
			action_q <= req_data.action;
			sector_q <= req_data.sector;
		end
		if (rd_s1 && (state_q == ST_LOOKUP || state_q == ST_LOOKUP_END)) begin
			if (valid_q[idx_s1] && cmp.tag_eq && !hit_q) begin
				hslot_q <= idx_s1;
				hrank_q <= rank_rdata;
			end
			if (!valid_q[idx_s1] && !free_found_q) begin
				free_q <= idx_s1;
			end
			// Ranks of valid entries are distinct, so only the oldest matches here.
			if (valid_q[idx_s1] && cmp.rank_eq) begin
				old_slot_q <= idx_s1;
				old_tag_q  <= tag_rdata;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_q.last <= 1'b1;
			if (hit_q) begin
				sel_q                  <= hslot_q;
				limit_q                <= {1'b0, hrank_q};
				res_q.hit              <= 1'b1;
				res_q.slot             <= SLOT_W'(hslot_q);
				res_q.fetch_needed     <= 1'b0;
				res_q.writeback_valid  <= 1'b0;
				res_q.writeback_sector <= '0;
			end else begin
				sel_q                  <= victim;
				limit_q                <= full ? {1'b0, oldest_rank} : AGE_ALL;
				res_q.hit              <= 1'b0;
				res_q.slot             <= SLOT_W'(victim);
				res_q.fetch_needed     <= (action_q == ACT_READ);
				res_q.writeback_valid  <= full;
				res_q.writeback_sector <= full ? old_tag_q : '0;
			end
		end
		if (state_q == ST_FL_MAP_END) begin
			flush_r_q <= oldest_rank;
		end
		if (state_q == ST_FL_EMIT && rsp_free && flush_r_q != '0) begin
			flush_r_q <= flush_r_q - IDX_W'(1);
		end
		if (state_q == ST_FL_TAG) begin
			wb_slot_q <= inv_rdata;
		end
		if (load_rsp) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import lsc_pkg::*;

	localparam int NSLOT = CACHE_ENTRIES_DEF;
	localparam int RAND_ITEMS = 410;
	localparam int HOT_SECTORS = 80;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// Shadow copy of the cache directory.
	logic [SECTOR_W-1:0] shadow_tag[NSLOT];
	bit                  shadow_valid[NSLOT];
	int unsigned         shadow_rank[NSLOT];
	int unsigned         shadow_occupied;

	rsp_t     staged_rsp[$];
	rsp_t     awaited_rsp[$];
	dir_row_t directed_reqs[$];
	logic [SECTOR_W-1:0] hot_sectors[HOT_SECTORS];

	int mismatches = 0;
	int delivered = 0;
	bit calm = 1'b0;

	always #4 clk = ~clk;

	lru_sector_cache_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	function automatic rsp_t mk_rsp(bit hit, int slot, bit fetch, bit wbv,
			logic [SECTOR_W-1:0] wbs, bit last);
		rsp_t r;
		r.hit = hit;
		r.slot = SLOT_W'(slot);
		r.fetch_needed = fetch;
		r.writeback_valid = wbv;
		r.writeback_sector = wbs;
		r.last = last;
		return r;
	endfunction

	function automatic dir_row_t dir_row(logic [1:0] act, logic [SECTOR_W-1:0] sec,
			bit typed, rsp_t want);
		dir_row_t d;
		d.req.action = act;
		d.req.sector = sec;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	// Slot s becomes the most recent; valid entries younger than old_rank age by one.
	function automatic void make_most_recent(int s, int unsigned old_rank);
		for (int j = 0; j < NSLOT; j++) begin
			if (j != s && shadow_valid[j] && shadow_rank[j] < old_rank)
				shadow_rank[j]++;
		end
		shadow_rank[s] = 0;
	endfunction

	function automatic int least_recent_slot();
		int best;
		best = -1;
		for (int j = 0; j < NSLOT; j++) begin
			if (shadow_valid[j] && (best < 0 || shadow_rank[j] > shadow_rank[best]))
				best = j;
		end
		return best;
	endfunction

	// Works out the results of one accepted request and leaves them in staged_rsp.
	function automatic void track_cache_access(req_t r);
		int s;
		int unsigned left;
		logic [SECTOR_W-1:0] old_tag;
		case (r.action)
			ACT_FLUSH: begin
				left = 0;
				for (int j = 0; j < NSLOT; j++)
					if (shadow_valid[j])
						left++;
				while (left > 0) begin
					s = least_recent_slot();
					if (s < 0)
						break;
					left--;
					staged_rsp.push_back(mk_rsp(0, s, 0, 1, shadow_tag[s], left == 0));
					shadow_valid[s] = 0;
				end
				for (int j = 0; j < NSLOT; j++)
					shadow_rank[j] = 0;
				shadow_occupied = 0;
			end
			ACT_READ, ACT_WRITE: begin
				for (int j = 0; j < NSLOT; j++) begin
					if (shadow_valid[j] && shadow_tag[j] == r.sector) begin
						make_most_recent(j, shadow_rank[j]);
						staged_rsp.push_back(mk_rsp(1, j, 0, 0, '0, 1));
						return;
					end
				end
				if (shadow_occupied < NSLOT) begin
					s = -1;
					for (int j = 0; j < NSLOT; j++) begin
						if (!shadow_valid[j]) begin
							s = j;
							break;
						end
					end
					if (s >= 0) begin
						shadow_valid[s] = 1;
						shadow_tag[s] = r.sector;
						make_most_recent(s, NSLOT);
						shadow_occupied++;
						staged_rsp.push_back(mk_rsp(0, s, r.action == ACT_READ, 0, '0, 1));
						return;
					end
					shadow_occupied = NSLOT;
				end
				// No free slot: the least recent entry is evicted and written back.
				s = least_recent_slot();
				if (s < 0)
					return;
				old_tag = shadow_tag[s];
				shadow_tag[s] = r.sector;
				make_most_recent(s, shadow_rank[s]);
				staged_rsp.push_back(mk_rsp(0, s, r.action == ACT_READ, 1, old_tag, 1));
			end
			default: ;
		endcase
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int p;
		p = $urandom_range(0, 199);
		r.sector = $urandom;
		if (p < 2)
			r.action = ACT_FLUSH;
		else if (p < 6)
			r.action = ACT_UNUSED;
		else begin
			r.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
			// Most requests come from a working set a little larger than the cache.
			if (p >= 30)
				r.sector = hot_sectors[$urandom_range(0, HOT_SECTORS - 1)];
		end
		return r;
	endfunction

	task automatic note_mismatch(string why, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s result: want hit=%0d slot=%0d fetch=%0d wb=%0d wb_sector=%h last=%0d, got hit=%0d slot=%0d fetch=%0d wb=%0d wb_sector=%h last=%0d",
				$time, why, want.hit, want.slot, want.fetch_needed, want.writeback_valid,
				want.writeback_sector, want.last, got.hit, got.slot, got.fetch_needed,
				got.writeback_valid, got.writeback_sector, got.last);
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic offer(req_t r, bit typed, rsp_t want);
		req_data <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		track_cache_access(r);
		if (typed) begin
			staged_rsp.delete();
			awaited_rsp.push_back(want);
		end else begin
			while (staged_rsp.size() != 0)
				awaited_rsp.push_back(staged_rsp.pop_front());
		end
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (awaited_rsp.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			delivered++;
			if (awaited_rsp.size() == 0)
				note_mismatch("unexpected", '0, rsp_data);
			else begin
				want = awaited_rsp.pop_front();
				if (want.hit !== rsp_data.hit || want.slot !== rsp_data.slot ||
						want.fetch_needed !== rsp_data.fetch_needed ||
						want.writeback_valid !== rsp_data.writeback_valid ||
						want.writeback_sector !== rsp_data.writeback_sector ||
						want.last !== rsp_data.last)
					note_mismatch("wrong", want, rsp_data);
			end
		end
	end

	// Result side: random stalls, plus one long hold-off that backs the block up.
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && delivered >= 30) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (600) @(negedge clk);
			end else if (calm || $urandom_range(0, 2) != 0)
				rsp_ready <= 1'b1;
			else begin
				rsp_ready <= 1'b0;
				repeat (idle_len() - 1) @(negedge clk);
			end
		end
	end

	initial begin
		req_t flush_req;
		for (int j = 0; j < NSLOT; j++) begin
			shadow_tag[j] = '0;
			shadow_valid[j] = 0;
			shadow_rank[j] = 0;
		end
		shadow_occupied = 0;
		flush_req.action = ACT_FLUSH;
		flush_req.sector = '0;

		// A flush of the empty cache and the unused action code give no result.
		directed_reqs.push_back(dir_row(ACT_FLUSH, 32'h0000_0000, 0, '0));
		directed_reqs.push_back(dir_row(ACT_UNUSED, 32'hFFFF_FFFF, 0, '0));
		directed_reqs.push_back(dir_row(ACT_READ, 32'h0000_0000, 1,
			mk_rsp(0, 0, 1, 0, '0, 1)));
		directed_reqs.push_back(dir_row(ACT_WRITE, 32'hFFFF_FFFF, 1,
			mk_rsp(0, 1, 0, 0, '0, 1)));
		directed_reqs.push_back(dir_row(ACT_READ, 32'hFFFF_FFFF, 1,
			mk_rsp(1, 1, 0, 0, '0, 1)));
		directed_reqs.push_back(dir_row(ACT_WRITE, 32'h0000_0000, 1,
			mk_rsp(1, 0, 0, 0, '0, 1)));
		directed_reqs.push_back(dir_row(ACT_READ, 32'hA5A5_A5A5, 1,
			mk_rsp(0, 2, 1, 0, '0, 1)));
		directed_reqs.push_back(dir_row(ACT_UNUSED, 32'hA5A5_A5A5, 0, '0));
		directed_reqs.push_back(dir_row(ACT_WRITE, 32'h5A5A_5A5A, 1,
			mk_rsp(0, 3, 0, 0, '0, 1)));
		directed_reqs.push_back(dir_row(ACT_READ, 32'h0000_0001, 0, '0));
		directed_reqs.push_back(dir_row(ACT_READ, 32'h8000_0000, 0, '0));
		directed_reqs.push_back(dir_row(ACT_WRITE, 32'h7FFF_FFFF, 0, '0));
		directed_reqs.push_back(dir_row(ACT_READ, 32'hFFFF_FFFF, 0, '0));
		directed_reqs.push_back(dir_row(ACT_FLUSH, 32'hFFFF_FFFF, 0, '0));
		directed_reqs.push_back(dir_row(ACT_READ, 32'hFFFF_FFFF, 1,
			mk_rsp(0, 0, 1, 0, '0, 1)));
		directed_reqs.push_back(dir_row(ACT_FLUSH, 32'h0000_0000, 1,
			mk_rsp(0, 0, 0, 1, 32'hFFFF_FFFF, 1)));
		directed_reqs.push_back(dir_row(ACT_FLUSH, 32'h1234_5678, 0, '0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_reqs[i]) begin
			offer(directed_reqs[i].req, directed_reqs[i].typed, directed_reqs[i].want);
			pause_sender(($urandom_range(0, 2) == 0) ? idle_len() : 0);
		end
		drain_results();

		for (int i = 0; i < HOT_SECTORS; i++)
			hot_sectors[i] = $urandom;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			calm = (i >= 120 && i < 180);
			if (i == 210)
				drain_results();
			// By this point the cache is normally full, so this flush empties every slot.
			offer((i == 300) ? flush_req : random_request(), 0, '0);
			pause_sender((!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0);
		end
		calm = 1'b0;
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
		mismatches += awaited_rsp.size();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#100ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
